@@ rtl/wfr_pkg.sv @@
package wfr_pkg;

   // Fixed field widths
   localparam int ACT_W   = 2;
   localparam int IDX_W   = 13;
   localparam int WORD_W  = 32;
   localparam int NPOS_W  = 12;
   localparam int FPOS_W  = 12;
   localparam int FMT_W   = 2;
   localparam int FCNT_W  = 13;
   localparam int LBEG_W  = 12;
   localparam int LFIN_W  = 13;
   localparam int GAIN_W  = 16;
   localparam int Q_W     = 24;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD    = 2'd0,
      ACT_SET_POS = 2'd1,
      ACT_FRAME   = 2'd2
   } action_type;

   typedef enum logic [FMT_W-1:0] {
      FMT_S16 = 2'd0,
      FMT_S24 = 2'd1,
      FMT_S32 = 2'd2,
      FMT_F32 = 2'd3
   } fmt_type;

   typedef enum logic [2:0] {
      REG_FORMAT      = 3'd0,
      REG_STEREO      = 3'd1,
      REG_LOOP_EN     = 3'd2,
      REG_FRAME_COUNT = 3'd3,
      REG_LOOP_BEGIN  = 3'd4,
      REG_LOOP_FINISH = 3'd5,
      REG_GAIN        = 3'd6
   } reg_type;

endpackage

@@ rtl/wfr_req_if.sv @@
interface wfr_req_if;
   logic                          valid;
   logic                          ready;
   logic [wfr_pkg::ACT_W-1:0]     action;
   logic [wfr_pkg::IDX_W-1:0]     word_index;
   logic [wfr_pkg::WORD_W-1:0]    word_data;
   logic [wfr_pkg::NPOS_W-1:0]    new_position;

   modport source (output valid, output action, output word_index, output word_data,
                   output new_position, input ready);
   modport sink (input valid, input action, input word_index, input word_data,
                 input new_position, output ready);
endinterface

@@ rtl/wfr_rsp_if.sv @@
interface wfr_rsp_if #(
   parameter int OUT_WIDTH = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [OUT_WIDTH-1:0]   left_sample;
   logic signed [OUT_WIDTH-1:0]   right_sample;
   logic                          frame_valid;
   logic [wfr_pkg::FPOS_W-1:0]    frame_position;

   modport source (output valid, output left_sample, output right_sample,
                   output frame_valid, output frame_position, input ready);
   modport sink (input valid, input left_sample, input right_sample,
                 input frame_valid, input frame_position, output ready);
endinterface

@@ rtl/wfr_ram.sv @@
module wfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

@@ rtl/wfr_sample_path.sv @@
module wfr_sample_path #(
   parameter int OUT_WIDTH = 24
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic [wfr_pkg::WORD_W-1:0]         word,
   input  wfr_pkg::fmt_type                   fmt,
   input  logic [wfr_pkg::GAIN_W-1:0]         gain,
   output logic signed [OUT_WIDTH-1:0]        sample
);

   localparam int PROD_W = wfr_pkg::Q_W + wfr_pkg::GAIN_W + 1;
   localparam int SHR_W  = PROD_W - 15;
   localparam logic [7:0] EXP_BIAS = 8'd127;
   localparam logic [7:0] EXP_LOW  = 8'd103;   // below this the value truncates to zero
   localparam logic [7:0] EXP_SPEC = 8'hFF;
   localparam logic signed [SHR_W-1:0] SAT_HI = SHR_W'(24'sh7FFFFF);
   localparam logic signed [SHR_W-1:0] SAT_LO = -SHR_W'(26'sh800000);

   logic signed [wfr_pkg::Q_W-1:0] dec_in;
   logic signed [wfr_pkg::Q_W-1:0] dec_ff;
   logic signed [PROD_W-1:0]       prod_in;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [SHR_W-1:0]        shr;
   logic signed [wfr_pkg::Q_W-1:0] sat;
   logic [31:0]                    sat_wide;

   logic        f_sgn;
   logic [7:0]  f_exp;
   logic [22:0] f_frac;
   logic [4:0]  f_sh;
   logic [23:0] f_mag;

   // Decode to Q1.23
   always_comb begin
      f_sgn  = word[31];
      f_exp  = word[30:23];
      f_frac = word[22:0];
      f_sh   = 5'(EXP_BIAS - f_exp);
      f_mag  = {1'b1, f_frac} >> f_sh;
      case (fmt)
         wfr_pkg::FMT_S16: dec_in = {word[15:0], 8'd0};
         wfr_pkg::FMT_S24: dec_in = word[23:0];
         wfr_pkg::FMT_S32: dec_in = word[31:8];
         wfr_pkg::FMT_F32: begin
            if (f_exp == EXP_SPEC && f_frac != 23'd0) begin
               dec_in = '0;                       // NaN
            end else if (f_exp == 8'd0) begin
               dec_in = '0;                       // zero and denormals
            end else if (f_exp >= EXP_BIAS) begin
               dec_in = f_sgn ? 24'h800000 : 24'h7FFFFF;
            end else if (f_exp < EXP_LOW) begin
               dec_in = '0;
            end else begin
               dec_in = f_sgn ? -f_mag : f_mag;
            end
         end
         default: dec_in = '0;
      endcase
   end

   assign prod_in = PROD_W'(dec_ff) * PROD_W'($signed({1'b0, gain}));

   always_ff @(posedge clock) begin
      if (en) begin
         dec_ff  <= dec_in;
         prod_ff <= prod_in;
      end
   end

   // Floor shift by 15, saturate, then rescale by taking the top bits
   always_comb begin
      shr = prod_ff[PROD_W-1:15];
      if (shr > SAT_HI) begin
         sat = 24'sh7FFFFF;
      end else if (shr < SAT_LO) begin
         sat = 24'sh800000;
      end else begin
         sat = shr[wfr_pkg::Q_W-1:0];
      end
      sat_wide = {sat, 8'd0};
   end

   assign sample = sat_wide[31 -: OUT_WIDTH];

endmodule

@@ rtl/wavetable_frame_reader_core.sv @@
// A frame passes the memory read, decode, product and output registers to rsp_ch.
// Throughput: one request of any kind per cycle while req_ch.ready is high.
// Each frame reads both channel words in one access of the dual-read sample memory.
// req_ch.ready drops only while the output skid register holds a stalled result.
// Reset (synchronous) clears the play position, pipeline and registers; gain returns to
// unity. Sample memory is not cleared.
module wavetable_frame_reader_core #(
   parameter int MAX_FRAMES = 4096,   // power of two
   parameter int OUT_WIDTH  = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   wfr_req_if.sink                          req_ch,
   wfr_rsp_if.source                        rsp_ch,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [wfr_pkg::CSR_AW-1:0]       paddr,
   input  logic [wfr_pkg::CSR_DW-1:0]       pwdata,
   output logic [wfr_pkg::CSR_DW-1:0]       prdata,
   output logic                             pready
);

   localparam int PW  = $clog2(MAX_FRAMES);
   localparam int AW  = PW + 1;
   localparam int EW  = ((PW > wfr_pkg::FCNT_W) ? PW : wfr_pkg::FCNT_W) + 1;
   localparam int MEM_WORDS = 2 * MAX_FRAMES;

   // Configuration registers
   wfr_pkg::fmt_type                 fmt_ff;
   logic                             stereo_ff;
   logic                             loop_en_ff;
   logic [wfr_pkg::FCNT_W-1:0]       frame_count_ff;
   logic [wfr_pkg::LBEG_W-1:0]       loop_begin_ff;
   logic [wfr_pkg::LFIN_W-1:0]       loop_finish_ff;
   logic [wfr_pkg::GAIN_W-1:0]       gain_ff;

   logic                             csr_wr;
   wfr_pkg::reg_type                 csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_sel = wfr_pkg::reg_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff         <= wfr_pkg::FMT_S16;
         stereo_ff      <= 1'b0;
         loop_en_ff     <= 1'b0;
         frame_count_ff <= '0;
         loop_begin_ff  <= '0;
         loop_finish_ff <= '0;
         gain_ff        <= wfr_pkg::GAIN_UNITY;
      end else if (csr_wr) begin
         case (csr_sel)
            wfr_pkg::REG_FORMAT:      fmt_ff         <= wfr_pkg::fmt_type'(pwdata[1:0]);
            wfr_pkg::REG_STEREO:      stereo_ff      <= pwdata[0];
            wfr_pkg::REG_LOOP_EN:     loop_en_ff     <= pwdata[0];
            wfr_pkg::REG_FRAME_COUNT: frame_count_ff <= pwdata[wfr_pkg::FCNT_W-1:0];
            wfr_pkg::REG_LOOP_BEGIN:  loop_begin_ff  <= pwdata[wfr_pkg::LBEG_W-1:0];
            wfr_pkg::REG_LOOP_FINISH: loop_finish_ff <= pwdata[wfr_pkg::LFIN_W-1:0];
            wfr_pkg::REG_GAIN:        gain_ff        <= pwdata[wfr_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         wfr_pkg::REG_FORMAT:      prdata = 32'(fmt_ff);
         wfr_pkg::REG_STEREO:      prdata = 32'(stereo_ff);
         wfr_pkg::REG_LOOP_EN:     prdata = 32'(loop_en_ff);
         wfr_pkg::REG_FRAME_COUNT: prdata = 32'(frame_count_ff);
         wfr_pkg::REG_LOOP_BEGIN:  prdata = 32'(loop_begin_ff);
         wfr_pkg::REG_LOOP_FINISH: prdata = 32'(loop_finish_ff);
         wfr_pkg::REG_GAIN:        prdata = 32'(gain_ff);
         default:                  prdata = '0;
      endcase
   end

   // Pipeline control
   logic                             adv;
   logic                             accept;
   wfr_pkg::action_type              act;
   logic [PW-1:0]                    pos_ff, pos_in;
   logic [EW-1:0]                    pos_ext, pos_inc_ext, newpos_ext, lbeg_ext, idx_ext;
   logic                             past_end, wrap;
   logic                             ram_we;
   logic [AW-1:0]                    rd_addr_a, rd_addr_b;
   logic [wfr_pkg::WORD_W-1:0]       rd_data_a, rd_data_b;

   logic                             s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                             s1_fvalid_ff, s2_fvalid_ff, s3_fvalid_ff;
   logic [wfr_pkg::FPOS_W-1:0]       s1_fpos_ff, s2_fpos_ff, s3_fpos_ff;

   logic                             skid_valid_ff;
   logic                             out_valid_ff;

   assign adv          = !skid_valid_ff;
   assign req_ch.ready = adv;
   assign accept       = req_ch.valid && adv;
   assign act          = wfr_pkg::action_type'(req_ch.action);

   assign pos_ext     = EW'(pos_ff);
   assign pos_inc_ext = pos_ext + EW'(1);
   assign newpos_ext  = EW'(req_ch.new_position);
   assign lbeg_ext    = EW'(loop_begin_ff);
   assign idx_ext     = EW'(req_ch.word_index);
   assign past_end    = !loop_en_ff && (pos_ext >= EW'(frame_count_ff));
   assign wrap        = loop_en_ff && (pos_inc_ext >= EW'(loop_finish_ff));

   always_comb begin
      pos_in = pos_ff;
      ram_we = 1'b0;
      if (accept) begin
         case (act)
            wfr_pkg::ACT_LOAD:    ram_we = 1'b1;
            wfr_pkg::ACT_SET_POS: pos_in = newpos_ext[PW-1:0];
            wfr_pkg::ACT_FRAME: begin
               if (!past_end) begin
                  pos_in = wrap ? lbeg_ext[PW-1:0] : pos_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Stereo frames occupy word pairs; mono frames one word each
   assign rd_addr_a = stereo_ff ? {pos_ff, 1'b0} : {1'b0, pos_ff};
   assign rd_addr_b = {pos_ff, 1'b1};

   wfr_ram #(
      .WIDTH (wfr_pkg::WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (idx_ext[AW-1:0]),
      .wr_data   (req_ch.word_data),
      .rd_en     (adv),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (adv) begin
            s1_valid_ff <= accept && (act == wfr_pkg::ACT_FRAME);
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_fvalid_ff <= !past_end;
         s1_fpos_ff   <= pos_ext[wfr_pkg::FPOS_W-1:0];
         s2_fvalid_ff <= s1_fvalid_ff;
         s2_fpos_ff   <= s1_fpos_ff;
         s3_fvalid_ff <= s2_fvalid_ff;
         s3_fpos_ff   <= s2_fpos_ff;
      end
   end

   logic signed [OUT_WIDTH-1:0] left_path, right_path;

   wfr_sample_path #(.OUT_WIDTH(OUT_WIDTH)) u_left (
      .clock  (clock),
      .en     (adv),
      .word   (rd_data_a),
      .fmt    (fmt_ff),
      .gain   (gain_ff),
      .sample (left_path)
   );

   wfr_sample_path #(.OUT_WIDTH(OUT_WIDTH)) u_right (
      .clock  (clock),
      .en     (adv),
      .word   (rd_data_b),
      .fmt    (fmt_ff),
      .gain   (gain_ff),
      .sample (right_path)
   );

   // Result assembly; past-end frames give zero samples
   logic                        push;
   logic signed [OUT_WIDTH-1:0] left_new, right_new;

   assign push      = s3_valid_ff && adv;
   assign left_new  = s3_fvalid_ff ? left_path : '0;
   assign right_new = !s3_fvalid_ff ? '0 : (stereo_ff ? right_path : left_path);

   // Output register plus one skid entry
   logic                        out_free;
   logic signed [OUT_WIDTH-1:0] out_left_ff, out_right_ff, skid_left_ff, skid_right_ff;
   logic                        out_fvalid_ff, skid_fvalid_ff;
   logic [wfr_pkg::FPOS_W-1:0]  out_fpos_ff, skid_fpos_ff;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_free) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_left_ff   <= skid_left_ff;
            out_right_ff  <= skid_right_ff;
            out_fvalid_ff <= skid_fvalid_ff;
            out_fpos_ff   <= skid_fpos_ff;
         end
      end else if (push) begin
         if (out_free) begin
            out_left_ff   <= left_new;
            out_right_ff  <= right_new;
            out_fvalid_ff <= s3_fvalid_ff;
            out_fpos_ff   <= s3_fpos_ff;
         end else begin
            skid_left_ff   <= left_new;
            skid_right_ff  <= right_new;
            skid_fvalid_ff <= s3_fvalid_ff;
            skid_fpos_ff   <= s3_fpos_ff;
         end
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.left_sample    = out_left_ff;
   assign rsp_ch.right_sample   = out_right_ff;
   assign rsp_ch.frame_valid    = out_fvalid_ff;
   assign rsp_ch.frame_position = out_fpos_ff;

endmodule
